// ===== sv/mfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared constants and types for the minifloat quantizer.
// ----------------------------------------------------------------------------
package mfq_pkg;

  localparam int unsigned FracBits = 23;
  localparam int unsigned F32Bias  = 127;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned RndFieldBits = 16;

  typedef enum logic [1:0] {
    REG_MANTISSA_BITS = 2'd0,
    REG_EXPONENT_BITS = 2'd1,
    REG_ROUNDING_MODE = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_index_t;

  typedef enum logic {
    ROUND_NEAREST    = 1'b0,
    ROUND_STOCHASTIC = 1'b1
  } round_mode_t;

  typedef struct packed {
    logic flushed;
    logic saturated;
  } out_flags_t;

endpackage

// ===== sv/minifloat_quantizer.sv =====
// ----------------------------------------------------------------------------
// minifloat_quantizer
// Rounds float32 words to a configurable minifloat format, returns float32.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while the output register is empty or
// out_tready is high; its result appears in the output register in the next
// cycle. All rounding, clamping and flushing is done by combinational logic in
// front of that register. Configuration is taken at any time on the cfg channel
// and applies to transactions accepted afterwards.
module minifloat_quantizer
  import mfq_pkg::*;
#(
  parameter int unsigned RANDOM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // value_bits[31:0], random_fraction[47:32]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_bits[31:0]
  output logic [1:0]  out_tuser,  // saturated[0], flushed[1]
  output logic        out_tlast
);

  localparam int unsigned SumW = RANDOM_BITS + FracBits + 1;

  logic [4:0] mant_bits_r;
  logic [3:0] exp_bits_r;
  logic       round_mode_r;

  logic        out_valid_r;
  logic [31:0] out_data_r;
  out_flags_t  out_flags_r;
  logic        out_last_r;

  logic [31:0] word;
  logic [RANDOM_BITS+RndFieldBits-1:0] rnd_ext;
  logic [RANDOM_BITS-1:0] rnd;
  logic        sign;
  logic [7:0]  efield;
  logic [22:0] frac;
  logic [4:0]  mb;
  logic [3:0]  eb;
  logic [4:0]  drop;
  logic [7:0]  bias;
  logic [8:0]  max_exp;
  logic signed [9:0] rebiased;
  logic [23:0] half;
  logic [23:0] mant_n;
  logic [SumW-1:0] num;
  logic [6:0]  sh_s;
  logic [23:0] mant_s;
  logic [23:0] mant_rnd;
  logic        carry;
  logic [23:0] mant;
  logic [8:0]  oexp;
  logic        flush;
  logic        sat;
  logic [31:0] result;
  logic        in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    word    = in_tdata[31:0];
    rnd_ext = {{RANDOM_BITS{1'b0}}, in_tdata[47:32]};
    rnd     = rnd_ext[RANDOM_BITS-1:0];
    sign    = word[31];
    efield  = word[30:23];
    frac    = word[22:0];
    mb      = (mant_bits_r > 5'd23) ? 5'd23 : mant_bits_r;
    eb      = (exp_bits_r < 4'd2) ? 4'd2 : ((exp_bits_r > 4'd8) ? 4'd8 : exp_bits_r);
    drop    = 5'd23 - mb;
    bias    = 8'((9'd1 << (eb - 4'd1)) - 9'd1);
    max_exp = 9'((10'd1 << eb) - 10'd1);
    rebiased = $signed({2'b00, efield}) - 10'sd127 + $signed({2'b00, bias});
    half    = (drop == 5'd0) ? 24'd0 : (24'd1 << (drop - 5'd1));
    mant_n  = ({1'b0, frac} + half) >> drop;
    num     = {1'b0, frac, {RANDOM_BITS{1'b0}}} + (SumW'(rnd) << drop);
    sh_s    = 7'(drop) + 7'(RANDOM_BITS);
    mant_s  = 24'(num >> sh_s);
    mant_rnd = (round_mode_t'(round_mode_r) == ROUND_STOCHASTIC) ? mant_s : mant_n;
    carry   = (mant_rnd >> mb) != 24'd0;
    flush   = (efield == 8'd0) || (rebiased < 10'sd0);
    sat     = !flush && (rebiased > $signed({1'b0, max_exp}));
    if (sat) begin
      oexp = 9'(bias) + 9'd128;
      mant = (24'd1 << mb) - 24'd1;
    end else begin
      oexp = {1'b0, efield} + 9'(carry);
      mant = carry ? 24'd0 : mant_rnd;
    end
    if (flush) begin
      result = 32'd0;
    end else if (oexp >= 9'd255) begin
      result = {sign, 8'hFF, 23'd0};
    end else begin
      result = {sign, oexp[7:0], 23'(mant << drop)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mant_bits_r  <= 5'd10;
      exp_bits_r   <= 4'd5;
      round_mode_r <= ROUND_NEAREST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (reg_index_t'(cfg_index))
          REG_MANTISSA_BITS: mant_bits_r  <= cfg_data;
          REG_EXPONENT_BITS: exp_bits_r   <= cfg_data[3:0];
          REG_ROUNDING_MODE: round_mode_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r            <= result;
      out_flags_r.flushed   <= flush;
      out_flags_r.saturated <= sat;
      out_last_r            <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_flags_r.flushed, out_flags_r.saturated};
  assign out_tlast  = out_last_r;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("saturated and flushed both set");

  a_flush_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata == 32'd0))
    else $error("flushed result is not zero");

  a_sat_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[30:23] != 8'd0))
    else $error("saturated result has zero exponent");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the minifloat quantizer against a predictor of the rounding, flush
// and saturation rules under random stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb;
  import mfq_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic        sat;
    logic        flush;
    logic        last;
  } quant_t;

  class quant_scoreboard;
    logic [4:0] mant_bits = 5'd10;
    logic [3:0] exp_bits = 4'd5;
    round_mode_t mode = ROUND_NEAREST;
    quant_t pending[$];
    int errors = 0;

    function void note_input(logic [31:0] w, logic [15:0] rnd, logic lst);
      quant_t q;
      int mb, eb, drop, bias, maxe, efield, reb, oexp;
      longint unsigned frac, mant, half, num;
      mb = (mant_bits > 23) ? 23 : mant_bits;
      eb = (exp_bits < 2) ? 2 : ((exp_bits > 8) ? 8 : exp_bits);
      drop = 23 - mb;
      bias = (1 << (eb - 1)) - 1;
      maxe = (1 << eb) - 1;
      efield = w[30:23];
      frac = w[22:0];
      reb = efield - 127 + bias;
      q.word = '0; q.sat = 0; q.flush = 0; q.last = lst;
      if (efield == 0 || reb < 0) begin
        q.flush = 1;
      end else begin
        if (reb > maxe) begin
          q.sat = 1;
          oexp = maxe - bias + 127;
          mant = (64'd1 << mb) - 1;
        end else begin
          oexp = efield;
          if (mode == ROUND_NEAREST) begin
            half = drop ? (64'd1 << (drop - 1)) : 0;
            mant = (frac + half) >> drop;
          end else begin
            num = (frac << 16) + (longint'(rnd) << drop);
            mant = num >> (drop + 16);
          end
          if ((mant >> mb) != 0) begin
            mant = 0;
            oexp++;
          end
        end
        if (oexp >= 255) q.word = {w[31], 8'hFF, 23'd0};
        else q.word = {w[31], 8'(oexp), 23'((mant << drop) & 64'h7FFFFF)};
      end
      pending.push_back(q);
    endfunction

    function void check_result(logic [31:0] d, logic [1:0] u, logic lst);
      quant_t q;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      q = pending.pop_front();
      if (d !== q.word) begin
        $error("result_bits expected %h actual %h", q.word, d); errors++;
      end
      if (u[0] !== q.sat) begin
        $error("saturated expected %b actual %b", q.sat, u[0]); errors++;
      end
      if (u[1] !== q.flush) begin
        $error("flushed expected %b actual %b", q.flush, u[1]); errors++;
      end
      if (lst !== q.last) begin
        $error("last_out expected %b actual %b", q.last, lst); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;
  logic in_tvalid = 0, in_tready, in_tlast = 0;
  logic [47:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0, out_tlast;
  logic [31:0] out_tdata;
  logic [1:0] out_tuser;
  logic stim_done = 0;
  quant_scoreboard sb = new();

  minifloat_quantizer u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #20_000_000;
    $display("[minifloat_quantizer] ERROR");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);

  initial begin : out_side
    int g;
    @(negedge clk);
    forever begin
      out_tready = 1;
      @(posedge clk);
      @(negedge clk);
      g = stim_done ? 0 : gap_len();
      if (g > 0) begin
        out_tready = 0;
        repeat (g) @(negedge clk);
      end
    end
  end

  task automatic write_reg(reg_index_t idx, logic [4:0] val);
    cfg_valid = 1; cfg_index = idx; cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MANTISSA_BITS: sb.mant_bits = val;
      REG_EXPONENT_BITS: sb.exp_bits = val[3:0];
      REG_ROUNDING_MODE: sb.mode = round_mode_t'(val[0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    in_tvalid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send(logic [31:0] w, logic [15:0] rnd, logic lst, bit gaps);
    int g;
    in_tvalid = 1; in_tdata = {rnd, w}; in_tlast = lst;
    do @(posedge clk); while (!in_tready);
    sb.note_input(w, rnd, lst);
    @(negedge clk);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid = 0;
      repeat (g) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_word(int mb, int eb);
    logic [31:0] w;
    int bias, p;
    w = $urandom();
    bias = (1 << (eb - 1)) - 1;
    p = $urandom_range(99);
    if (p < 70) w[30:23] = 8'(127 - bias + $urandom_range(0, (1 << eb)));
    else if (p < 78) w[30:23] = 8'd0;
    else if (p < 84) w[30:23] = 8'd255;
    else if (p < 88) w[30:23] = 8'd254;
    if ($urandom_range(3) == 0) begin
      if (mb < 23) w[22:0] = w[22:0] | ((23'd1 << (23 - mb)) - 23'd1) << mb * 0;
      w[22:0] = $urandom_range(1) ? ~(w[22:0] & 23'h0) : w[22:0];
    end
    return w;
  endfunction

  initial begin : stimulus
    int mb, eb;
    logic [31:0] dir[$] = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                            32'h3F80_0000, 32'hBF80_0000, 32'h3FFF_FFFF, 32'h3F80_1000,
                            32'h3F80_0FFF, 32'h477F_F000, 32'h477F_FFFF, 32'h4780_0000,
                            32'hC780_0000, 32'h3880_0000, 32'h3800_0000, 32'h7F80_0000,
                            32'hFF80_0000, 32'h7FC0_0001, 32'h7F7F_FFFF, 32'hFFFF_FFFF};
    repeat (2) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    foreach (dir[i]) send(dir[i], 16'hFFFF, i[0], 1);
    drain();
    write_reg(REG_ROUNDING_MODE, 5'd1);
    foreach (dir[i]) send(dir[i], i[0] ? 16'hFFFF : 16'h0000, ~i[0], 1);
    drain();
    write_reg(REG_MANTISSA_BITS, 5'd23);
    write_reg(REG_EXPONENT_BITS, 5'd8);
    foreach (dir[i]) send(dir[i], 16'h8000, 0, 0);
    drain();
    write_reg(REG_EXPONENT_BITS, 5'd15);
    write_reg(REG_MANTISSA_BITS, 5'd31);
    send(32'h7F7F_FFFF, 16'hFFFF, 1, 1);
    send(32'h3F80_0001, 16'hFFFF, 0, 1);
    drain();
    for (int ph = 0; ph < 25; ph++) begin
      mb = (ph % 5 == 0) ? 0 : ((ph % 5 == 1) ? 23 : $urandom_range(0, 31));
      eb = (ph % 4 == 0) ? 2 : ((ph % 4 == 1) ? 8 : $urandom_range(0, 15));
      write_reg(REG_MANTISSA_BITS, 5'(mb));
      write_reg(REG_EXPONENT_BITS, 5'(eb));
      write_reg(REG_ROUNDING_MODE, 5'($urandom_range(1)));
      mb = (mb > 23) ? 23 : mb;
      eb = (eb < 2) ? 2 : ((eb > 8) ? 8 : eb);
      for (int k = 0; k < 50; k++)
        send(rand_word(mb, eb), 16'($urandom()), 1'($urandom()), ph % 3 != 2);
      in_tvalid = 0;
      drain();
    end
    stim_done = 1;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[minifloat_quantizer] OK");
    else
      $display("[minifloat_quantizer] ERROR");
    $finish;
  end
endmodule
